// ===== hw/rtl/sdwq_pkg.sv =====
package sdwq_pkg;

    // table and result limits
    localparam int CAPACITY     = 32;
    localparam int TASK_ID_BITS = 8;
    localparam int MAX_RESULTS  = 32;

    // field widths
    localparam int MODE_W = 2;
    localparam int TASK_W = 8;
    localparam int TIME_W = 31;
    localparam int KIND_W = 2;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [TASK_W-1:0] TASK_MASK = TASK_W'((1 << TASK_ID_BITS) - 1);

    // input modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ABS   = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WAKE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVF  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic              latch;
        logic              tick_inc;
        logic              insert;
        logic              pop;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              use_head;
        logic              last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              sum_ovf;
        logic              full;
        logic              abs_past;
        logic              head_due;
        logic              second_due;
    } status_t;

endpackage

// ===== hw/rtl/sdwq_ctrl.sv =====
module sdwq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sdwq_pkg::status_t status,
    output sdwq_pkg::cmd_t   cmd,
    output logic             busy
);
    import sdwq_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EXEC    = 2'd1;
    localparam logic [1:0] ST_RELEASE = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [RES_W-1:0] n_reg;
    logic [RES_W-1:0] n_next;

    // state and release counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        cmd        = '0;
        cmd.kind   = KIND_WAKE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (status.mode)
                    MODE_TICK:
                    begin
                        cmd.tick_inc = 1'b1;
                        n_next       = '0;
                        state_next   = ST_RELEASE;
                    end
                    MODE_QUERY:
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = KIND_TIME;
                        cmd.last = 1'b1;
                    end
                    MODE_REL:
                    begin
                        if (status.sum_ovf)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_OVF;
                            cmd.last = 1'b1;
                        end
                        else if (status.full)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_FULL;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.insert = 1'b1;
                        end
                    end
                    default:
                    begin
                        // absolute wake time
                        if (status.abs_past)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_WAKE;
                            cmd.last = 1'b1;
                        end
                        else if (status.full)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_FULL;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.insert = 1'b1;
                        end
                    end
                endcase
            end
            ST_RELEASE:
            begin
                // one due task a cycle from the head of the table
                if (status.head_due)
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = KIND_WAKE;
                    cmd.use_head = 1'b1;
                    cmd.pop      = 1'b1;
                    cmd.last     = (n_reg == RES_W'(MAX_RESULTS - 1)) || !status.second_due;
                    n_next       = n_reg + 1'b1;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sdwq_datapath.sv =====
module sdwq_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sdwq_pkg::MODE_W-1:0]     mode,
    input  logic [sdwq_pkg::TASK_W-1:0]     requester,
    input  logic [sdwq_pkg::TIME_W-1:0]     amount,
    input  sdwq_pkg::cmd_t                  cmd,
    output sdwq_pkg::status_t               status,
    output logic                            done,
    output logic [sdwq_pkg::KIND_W-1:0]     kind,
    output logic [sdwq_pkg::TASK_W-1:0]     task_res,
    output logic [sdwq_pkg::TIME_W-1:0]     now,
    output logic                            last
);
    import sdwq_pkg::*;

    localparam int SECOND = (CAPACITY > 1) ? 1 : 0;

    // latched item
    logic [MODE_W-1:0] mode_reg;
    logic [TASK_W-1:0] who_reg;
    logic [TIME_W-1:0] amount_reg;

    // counters
    logic [TIME_W-1:0] tick_reg;
    logic [CNT_W-1:0]  count_reg;

    // sorted chain
    logic [TIME_W-1:0] wake_reg [CAPACITY];
    logic [TASK_W-1:0] task_reg [CAPACITY];
    logic [TIME_W-1:0] wake_next [CAPACITY];
    logic [TASK_W-1:0] task_next [CAPACITY];

    // output register
    logic              done_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [TASK_W-1:0] res_task_reg;
    logic [TIME_W-1:0] now_reg;
    logic              last_reg;

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] when;
    logic [CAPACITY-1:0] le;
    logic [CAPACITY-1:0] le_prev;

    // wake time of a delay
    assign sum  = {1'b0, tick_reg} + {1'b0, amount_reg};
    assign when = (mode_reg == MODE_REL) ? sum[TIME_W-1:0] : amount_reg;

    // status towards the controller
    assign status.mode       = mode_reg;
    assign status.sum_ovf    = sum[TIME_W];
    assign status.full       = (count_reg >= CNT_W'(CAPACITY));
    assign status.abs_past   = (amount_reg <= tick_reg);
    assign status.head_due   = (count_reg != '0) && (wake_reg[0] <= tick_reg);
    assign status.second_due = (count_reg > CNT_W'(1)) && (wake_reg[SECOND] <= tick_reg);

    // per-entry compare: valid entries that wake no later than the new one
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            le[i] = (CNT_W'(i) < count_reg) && (wake_reg[i] <= when);
        end
        le_prev[0] = 1'b1;
        for (int i = 1; i < CAPACITY; i++)
        begin
            le_prev[i] = le[i-1];
        end
    end

    // chain next value: insert shifts right past the slot, pop shifts left
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            wake_next[i] = wake_reg[i];
            task_next[i] = task_reg[i];
        end
        if (cmd.insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (!le[i])
                begin
                    if (le_prev[i])
                    begin
                        wake_next[i] = when;
                        task_next[i] = who_reg;
                    end
                    else
                    begin
                        wake_next[i] = wake_reg[(i > 0) ? i - 1 : 0];
                        task_next[i] = task_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                wake_next[i] = wake_reg[i+1];
                task_next[i] = task_reg[i+1];
            end
        end
    end

    // table payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            wake_reg[i] <= wake_next[i];
            task_reg[i] <= task_next[i];
        end
    end

    // item latch and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg   <= mode;
            who_reg    <= requester & TASK_MASK;
            amount_reg <= amount;
        end
        if (cmd.emit)
        begin
            kind_reg     <= cmd.kind;
            res_task_reg <= cmd.use_head ? task_reg[0] : who_reg;
            now_reg      <= tick_reg;
            last_reg     <= cmd.last;
        end
    end

    // control state: tick count, fill count, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.tick_inc && (tick_reg != TIME_MAX))
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (cmd.insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign kind     = kind_reg;
    assign task_res = res_task_reg;
    assign now      = now_reg;
    assign last     = last_reg;

endmodule

// ===== hw/rtl/sorted_delay_wakeup_queue_top.sv =====
// sorted delay wakeup queue
//
// input: an item is taken at a rising edge with start high and busy low;
// mode, requester and amount are sampled at that edge.
// output: each result is shown for one cycle with done high; kind,
// task_res, now and last are valid only then, and last marks the final
// result of an item. the receiver cannot stall: results are never held.
// order: the item is latched, the execute state handles it, and a query
// result or a delay's immediate result (overflow, full or past wake time)
// goes out via the output register; a tick counts up, then releases tasks.
// busy: delay and query items hold busy high in the execute state only;
// a tick also holds it through the release state, which frees up to 32
// due tasks, one a cycle from the head of the sorted chain.
// on an insert every chain slot compares its wake time in parallel and
// the chain shifts right past the insertion point.
// reset clears the tick count, the entry count and the result strobe;
// the table is empty at once and a start may follow straight away.
module sorted_delay_wakeup_queue_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sdwq_pkg::MODE_W-1:0] mode,
    input  logic [sdwq_pkg::TASK_W-1:0] requester,
    input  logic [sdwq_pkg::TIME_W-1:0] amount,
    output logic                        done,
    output logic [sdwq_pkg::KIND_W-1:0] kind,
    output logic [sdwq_pkg::TASK_W-1:0] task_res,
    output logic [sdwq_pkg::TIME_W-1:0] now,
    output logic                        last
);
    import sdwq_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    sdwq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // counters, sorted chain and output register
    sdwq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .requester (requester),
        .amount    (amount),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .kind      (kind),
        .task_res  (task_res),
        .now       (now),
        .last      (last)
    );

endmodule
